/* hdl/ssrr_pkg.sv */
package ssrr_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_ADVANCE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
    } cmd_t;

    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] cursor_key;
        logic             cursor_valid;
        logic [CNT_W-1:0] entry_count;
    } result_t;

    // broadcast to every cell during the execute cycle
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             adv;
        logic             head_set;
        logic [KEY_W-1:0] k;
    } ctrl_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             cur;
        logic             lt;
    } nb_t;

endpackage

/* hdl/ssrr_cell.sv */
module ssrr_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  ssrr_pkg::ctrl_t ctrl,
    input  logic           head,
    input  logic           occ,
    input  logic           last,
    input  ssrr_pkg::nb_t  left,
    input  ssrr_pkg::nb_t  right,
    output ssrr_pkg::nb_t  self_nb,
    output logic           eq
);
    import ssrr_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             cur_reg;
    logic             cur_next;
    logic             lt;
    logic             is_pos;

    assign lt     = occ && (key_reg < ctrl.k);
    assign eq     = occ && (key_reg == ctrl.k);
    // first cell whose key is not below k
    assign is_pos = !lt && (head || left.lt);

    assign self_nb.key = key_reg;
    assign self_nb.cur = cur_reg;
    assign self_nb.lt  = lt;

    always_comb
    begin
        key_next = key_reg;
        cur_next = cur_reg;
        if (ctrl.ins)
        begin
            if (!lt)
            begin
                key_next = is_pos ? ctrl.k : left.key;
                cur_next = is_pos ? 1'b0 : left.cur;
            end
            cur_next = cur_next | (head & ctrl.head_set);
        end
        else if (ctrl.del)
        begin
            if (!lt)
            begin
                key_next = right.key;
                cur_next = (is_pos & cur_reg & !last) | right.cur;
            end
            cur_next = cur_next | (head & ctrl.head_set);
        end
        else if (ctrl.adv)
        begin
            cur_next = (left.cur & occ) | (head & ctrl.head_set);
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= 1'b0;
        end
        else
        begin
            cur_reg <= cur_next;
        end
    end

endmodule

/* hdl/sorted_set_with_round_robin_cursor_top.sv */
// an accepted item passes through the execute state, then its result is strobed by the done register
// a new item is held off by busy while the cell row executes the current one
// every cell compares against the key and shifts with its neighbors in the execute state
// reset: set empty, no cursor, key cells undefined until written; no clearing pass
// done lasts one cycle and the receiver cannot stall it
module sorted_set_with_round_robin_cursor_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ssrr_pkg::cmd_t    cmd,
    output logic              done,
    output ssrr_pkg::result_t result
);
    import ssrr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [1:0]       op_reg;
    logic [KEY_W-1:0] k_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    status_t          status_reg;
    status_t          status_next;
    logic             done_reg;

    ctrl_t            ctrl;
    nb_t              nb     [CAPACITY];
    logic [CAPACITY-1:0] eq_v;
    logic [CAPACITY-1:0] occ_v;
    logic [CAPACITY-1:0] last_v;
    logic [CAPACITY-1:0] cur_v;

    logic             exec;
    logic             found;
    logic             full;
    logic             empty;
    logic             adv_wrap;
    logic             del_wrap;
    logic [KEY_W-1:0] cur_key;

    assign exec  = (state_reg == S_EXEC);
    assign busy  = exec;
    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            nb_t left_nb;
            nb_t right_nb;

            assign occ_v[gi] = (count_reg > CNT_W'(gi));
            assign cur_v[gi] = nb[gi].cur;

            if (gi == 0)
            begin : g_head
                assign left_nb = '0;
            end
            else
            begin : g_mid
                assign left_nb = nb[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_nb   = '0;
                assign last_v[gi] = occ_v[gi];
            end
            else
            begin : g_body
                assign right_nb   = nb[gi+1];
                assign last_v[gi] = occ_v[gi] & (count_reg == CNT_W'(gi + 1));
            end

            ssrr_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .head    (gi == 0),
                .occ     (occ_v[gi]),
                .last    (last_v[gi]),
                .left    (left_nb),
                .right   (right_nb),
                .self_nb (nb[gi]),
                .eq      (eq_v[gi])
            );
        end
    endgenerate

    assign found    = |eq_v;
    assign adv_wrap = |(cur_v & last_v);
    // deleting the cursor key at the top end wraps the cursor to the smallest key
    assign del_wrap = (|(eq_v & cur_v & last_v)) && (count_reg != CNT_W'(1));

    always_comb
    begin
        ctrl.k        = k_reg;
        ctrl.ins      = exec && (op_reg == OP_INSERT) && !found && !full;
        ctrl.del      = exec && (op_reg == OP_DELETE) && found;
        ctrl.adv      = exec && (op_reg == OP_ADVANCE) && !empty;
        ctrl.head_set = 1'b0;
        if (ctrl.ins)
        begin
            ctrl.head_set = empty;
        end
        else if (ctrl.del)
        begin
            ctrl.head_set = del_wrap;
        end
        else if (ctrl.adv)
        begin
            ctrl.head_set = adv_wrap | !(|cur_v);
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        count_next  = count_reg;
        case (op_reg)
            OP_INSERT:
            begin
                if (found)
                begin
                    status_next = ST_DUP;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_NOTFOUND;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_ADVANCE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg <= cmd.op;
            k_reg  <= cmd.key;
        end
        if (exec)
        begin
            status_reg <= status_next;
        end
    end

    // cursor is one-hot over occupied cells, so an and-or picks its key
    always_comb
    begin
        cur_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cur_key = cur_key | (nb[i].key & {KEY_W{cur_v[i]}});
        end
    end

    assign done                = done_reg;
    assign result.status       = status_reg;
    assign result.cursor_key   = cur_key;
    assign result.cursor_valid = |cur_v;
    assign result.entry_count  = count_reg;

endmodule

/* tb/sv/sorted_set_result_check.sv */
`timescale 1ns / 100ps

module sorted_set_result_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  ssrr_pkg::cmd_t    cmd,
    input  logic              done,
    input  ssrr_pkg::result_t result,
    output int                errors,
    output int                pending
);
    import ssrr_pkg::*;

    // shadow of the sorted set and its cursor
    logic [KEY_W-1:0] set_keys [CAPACITY];
    int               set_count;
    int               cur_idx;
    bit               cur_on;

    result_t          expected_q [$];

    // first slot holding a key >= k
    function automatic int lower_slot(input logic [KEY_W-1:0] k);
        int i;
        i = 0;
        while (i < set_count && set_keys[i] < k)
            i++;
        return i;
    endfunction

    function automatic result_t apply_cmd(input cmd_t c);
        result_t r;
        status_t st;
        int      p;
        int      i;
        st = ST_OK;
        case (c.op)
            OP_INSERT:
            begin
                p = lower_slot(c.key);
                if (p < set_count && set_keys[p] == c.key)
                    st = ST_DUP;
                else if (set_count >= CAPACITY)
                    st = ST_FULL;
                else
                begin
                    for (i = set_count; i > p; i--)
                        set_keys[i] = set_keys[i-1];
                    set_keys[p] = c.key;
                    set_count++;
                    if (set_count == 1)
                    begin
                        cur_idx = 0;
                        cur_on  = 1'b1;
                    end
                    else if (cur_on && p <= cur_idx)
                        cur_idx++;
                end
            end
            OP_DELETE:
            begin
                if (set_count == 0)
                    st = ST_EMPTY;
                else
                begin
                    p = lower_slot(c.key);
                    if (p >= set_count || set_keys[p] != c.key)
                        st = ST_NOTFOUND;
                    else
                    begin
                        for (i = p; i + 1 < set_count; i++)
                            set_keys[i] = set_keys[i+1];
                        set_count--;
                        if (set_count == 0)
                        begin
                            cur_idx = 0;
                            cur_on  = 1'b0;
                        end
                        else if (cur_on)
                        begin
                            if (cur_idx > p)
                                cur_idx--;
                            else if (cur_idx == p && p >= set_count)
                                cur_idx = 0;
                        end
                    end
                end
            end
            OP_ADVANCE:
            begin
                if (set_count == 0)
                    st = ST_EMPTY;
                else if (!cur_on)
                begin
                    cur_idx = 0;
                    cur_on  = 1'b1;
                end
                else
                begin
                    cur_idx++;
                    if (cur_idx >= set_count)
                        cur_idx = 0;
                end
            end
            default: ;
        endcase
        r.status       = st;
        r.cursor_key   = (cur_on && cur_idx < set_count) ? set_keys[cur_idx] : '0;
        r.cursor_valid = cur_on;
        r.entry_count  = CNT_W'(set_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        bit      bad;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                set_keys[i] = '0;
            set_count = 0;
            cur_idx   = 0;
            cur_on    = 1'b0;
            expected_q.delete();
            errors    = 0;
            pending   = 0;
        end
        else
        begin
            // the result of an older item leaves before a new item is predicted
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: st=%0d key=%h v=%b n=%0d",
                                 result.status, result.cursor_key,
                                 result.cursor_valid, result.entry_count);
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad  = (result.status !== want.status)
                         | (result.cursor_key !== want.cursor_key)
                         | (result.cursor_valid !== want.cursor_valid)
                         | (result.entry_count !== want.entry_count);
                    if (bad)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp st=%0d key=%h v=%b n=%0d",
                                      " got st=%0d key=%h v=%b n=%0d"},
                                     want.status, want.cursor_key,
                                     want.cursor_valid, want.entry_count,
                                     result.status, result.cursor_key,
                                     result.cursor_valid, result.entry_count);
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(apply_cmd(cmd));
            pending = expected_q.size();
        end
    end

endmodule

/* tb/sv/sorted_set_with_round_robin_cursor_top_tb.sv */
`timescale 1ns / 100ps

module sorted_set_with_round_robin_cursor_top_tb;
    import ssrr_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         N_ITEMS   = 760;
    localparam int         LIMIT     = 200000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;
    int      errors;
    int      pending;

    int      sent;
    int      burst_left;
    int      cycle_count;

    sorted_set_with_round_robin_cursor_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    sorted_set_result_check u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // present one item, hold it until taken, then maybe pause between bursts
    task automatic send_cmd(input logic [1:0] op, input logic [KEY_W-1:0] key);
        cmd_t c;
        int   gap;
        c.op  = op;
        c.key = key;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] k;
        logic [1:0]       op;
        int               stride;
        int               w_ins;
        int               w_del;
        int               r;
        int               mode;

        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        sent       = 0;
        burst_left = 5;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty set, extremes, duplicates, cursor wraps, last key removal
        send_cmd(OP_ADVANCE, 16'h0000);
        send_cmd(OP_DELETE,  16'h0000);
        send_cmd(OP_UNUSED,  16'h0000);
        send_cmd(OP_INSERT,  16'h8000);
        send_cmd(OP_INSERT,  16'h0000);
        send_cmd(OP_INSERT,  16'hFFFF);
        send_cmd(OP_INSERT,  16'h0000);
        send_cmd(OP_DELETE,  16'h1234);
        send_cmd(OP_ADVANCE, 16'hFFFF);
        send_cmd(OP_DELETE,  16'hFFFF);
        send_cmd(OP_INSERT,  16'h5555);
        send_cmd(OP_INSERT,  16'hAAAA);
        send_cmd(OP_DELETE,  16'h0000);
        send_cmd(OP_UNUSED,  16'hFFFF);
        send_cmd(OP_DELETE,  16'h5555);
        send_cmd(OP_DELETE,  16'h8000);
        send_cmd(OP_ADVANCE, 16'h0000);
        send_cmd(OP_DELETE,  16'hAAAA);
        send_cmd(OP_ADVANCE, 16'h0000);

        while (sent < N_ITEMS)
        begin
            mode = $urandom_range(0, 3);
            base = KEY_W'($urandom_range(0, 16'hFFFF));
            if (mode == 0)
            begin
                // fill past capacity, then drain the same keys
                stride = $urandom_range(1, 900);
                for (int i = 0; i < 72; i++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_cmd(OP_ADVANCE, KEY_W'($urandom_range(0, 16'hFFFF)));
                    send_cmd(OP_INSERT, base + KEY_W'(i * stride));
                end
                for (int i = 0; i < 90; i++)
                begin
                    k = base + KEY_W'($urandom_range(0, 71) * stride);
                    if ($urandom_range(0, 3) == 0)
                        send_cmd(OP_ADVANCE, k);
                    else
                        send_cmd(OP_DELETE, k);
                end
            end
            else if (mode == 3)
            begin
                for (int i = 0; i < 40; i++)
                    send_cmd(2'($urandom_range(0, 3)), KEY_W'($urandom_range(0, 16'hFFFF)));
            end
            else
            begin
                // dense keys so that hits, misses and cursor deletes are common
                stride = $urandom_range(1, 4);
                w_ins  = $urandom_range(20, 60);
                w_del  = 75 - w_ins;
                for (int i = 0; i < 100; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < w_ins)
                        op = OP_INSERT;
                    else if (r < w_ins + w_del)
                        op = OP_DELETE;
                    else if (r < 95)
                        op = OP_ADVANCE;
                    else
                        op = OP_UNUSED;
                    send_cmd(op, base + KEY_W'($urandom_range(0, 90) * stride));
                end
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sorted_set_with_round_robin_cursor_top.f */
hdl/ssrr_pkg.sv
hdl/ssrr_cell.sv
hdl/sorted_set_with_round_robin_cursor_top.sv
tb/sv/sorted_set_result_check.sv
tb/sv/sorted_set_with_round_robin_cursor_top_tb.sv
